// File: hdl/mmca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmca_pkg
// Shared types and constants of the macroblock motion copy address generator.
// ----------------------------------------------------------------------------
package mmca_pkg;

    // Macroblock geometry.
    localparam int MB_LUMA   = 16;
    localparam int MB_CHROMA = 8;
    localparam int NUM_ROWS  = MB_LUMA + MB_CHROMA;

    // Field and counter widths.
    localparam int POS_W     = 13;
    localparam int LSTRIDE_W = 13;
    localparam int CSTRIDE_W = 12;
    localparam int SRC_W     = 25;
    localparam int DST_W     = 24;
    localparam int LEN_W     = 5;
    localparam int CNT_W     = $clog2(NUM_ROWS);

    // Command codes and plane codes.
    localparam logic OP_FRAME     = 1'b0;
    localparam logic OP_FIELD     = 1'b1;
    localparam logic PLANE_LUMA   = 1'b0;
    localparam logic PLANE_CHROMA = 1'b1;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_REF_LUMA_STRIDE    = 2'd0,
        REG_DEST_LUMA_STRIDE   = 2'd1,
        REG_REF_CHROMA_STRIDE  = 2'd2,
        REG_DEST_CHROMA_STRIDE = 2'd3
    } t_reg_idx;

    // One classified macroblock command as held in the queue.
    typedef struct packed {
        logic                    field;
        logic [6:0]              col;
        logic [6:0]              row;
        logic signed [POS_W-1:0] sx_top;
        logic signed [POS_W-1:0] sy_top;
        logic signed [POS_W-1:0] sx_bot;
        logic signed [POS_W-1:0] sy_bot;
    } t_cmd;

    // Row pitches of the four planes.
    typedef struct packed {
        logic [LSTRIDE_W-1:0] ref_luma;
        logic [LSTRIDE_W-1:0] dest_luma;
        logic [CSTRIDE_W-1:0] ref_chroma;
        logic [CSTRIDE_W-1:0] dest_chroma;
    } t_strides;

endpackage

// File: hdl/mmca_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmca_front
// Classifies an incoming command and forms the luma source positions.
// ----------------------------------------------------------------------------
module mmca_front import mmca_pkg::*; (
    input  logic              i_operation,
    input  logic [6:0]        i_mb_col,
    input  logic [6:0]        i_mb_row,
    input  logic signed [10:0] i_mv_x_top,
    input  logic signed [10:0] i_mv_y_top,
    input  logic signed [10:0] i_mv_x_bottom,
    input  logic signed [10:0] i_mv_y_bottom,
    output t_cmd              o_cmd
);

    logic signed [POS_W-1:0] col_px;
    logic signed [POS_W-1:0] row_px;

    // Macroblock position in pixels.
    assign col_px = $signed({2'b00, i_mb_col, 4'b0000});
    assign row_px = $signed({2'b00, i_mb_row, 4'b0000});

    // Position plus vector for both fields; frame mode only uses the top pair.
    always_comb begin
        o_cmd.field  = (i_operation == OP_FIELD);
        o_cmd.col    = i_mb_col;
        o_cmd.row    = i_mb_row;
        o_cmd.sx_top = col_px + POS_W'(i_mv_x_top);
        o_cmd.sy_top = row_px + POS_W'(i_mv_y_top);
        o_cmd.sx_bot = col_px + POS_W'(i_mv_x_bottom);
        o_cmd.sy_bot = row_px + POS_W'(i_mv_y_bottom);
    end

endmodule

// File: hdl/mmca_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmca_queue
// Two-entry command queue between the front and the row sequencer.
// ----------------------------------------------------------------------------
module mmca_queue import mmca_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_head
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_full  = r_count[1];
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_mem[r_rd_ptr];

endmodule

// File: hdl/mmca_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmca_back
// Row sequencer and three-stage address pipeline producing the descriptors.
// ----------------------------------------------------------------------------
module mmca_back import mmca_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    input  t_cmd                    i_q_head,
    input  t_strides                i_strides,
    output logic                    o_pop,
    output logic                    o_strobe,
    output logic                    o_plane,
    output logic                    o_ref_select,
    output logic signed [SRC_W-1:0] o_src_offset,
    output logic [DST_W-1:0]        o_dst_offset,
    output logic [LEN_W-1:0]        o_row_length,
    output logic                    o_last
);

    localparam logic [CNT_W-1:0] LAST_ROW   = CNT_W'(NUM_ROWS - 1);
    localparam logic [CNT_W-1:0] FIRST_CHR  = CNT_W'(MB_LUMA);
    localparam int               SPROD_W    = 2 * POS_W + 1;
    localparam int               SSUM_W     = SPROD_W + 1;
    localparam logic signed [SSUM_W-1:0] SRC_LO = -(SSUM_W'(1) <<< (SRC_W - 1));
    localparam logic signed [SSUM_W-1:0] SRC_HI = (SSUM_W'(1) <<< (SRC_W - 1)) - SSUM_W'(1);

    // Halve a position, truncating toward zero.
    function automatic logic signed [POS_W-1:0] half_tz(input logic signed [POS_W-1:0] v);
        logic signed [POS_W-1:0] t;
        t = v + $signed({{(POS_W-1){1'b0}}, v[POS_W-1]});
        return t >>> 1;
    endfunction

    // Sequencer state.
    logic             r_active;
    logic [CNT_W-1:0] r_cnt;
    t_cmd             r_cmd;

    // Stage 1 registers.
    logic                    r_s1_valid;
    logic                    r_s1_plane;
    logic                    r_s1_sel;
    logic                    r_s1_last;
    logic signed [POS_W-1:0] r_s1_srow;
    logic [LSTRIDE_W-1:0]    r_s1_rstride;
    logic signed [POS_W-1:0] r_s1_sx;
    logic [10:0]             r_s1_drow;
    logic [LSTRIDE_W-1:0]    r_s1_dstride;
    logic [10:0]             r_s1_dcol;

    // Stage 2 registers.
    logic                      r_s2_valid;
    logic                      r_s2_plane;
    logic                      r_s2_sel;
    logic                      r_s2_last;
    logic signed [SPROD_W-1:0] r_s2_sprod;
    logic signed [POS_W-1:0]   r_s2_sx;
    logic [DST_W-1:0]          r_s2_dprod;
    logic [10:0]               r_s2_dcol;

    // Output registers.
    logic                    r_strobe;
    logic                    r_plane;
    logic                    r_sel;
    logic                    r_last;
    logic signed [SRC_W-1:0] r_src;
    logic [DST_W-1:0]        r_dst;

    // Stage 1 next values.
    logic                    is_chroma;
    logic [3:0]              y;
    logic [3:0]              y_off;
    logic                    n_sel;
    logic signed [POS_W-1:0] sx_pick;
    logic signed [POS_W-1:0] sy_pick;
    logic signed [POS_W-1:0] n_sx;
    logic signed [POS_W-1:0] base_y;
    logic signed [POS_W-1:0] n_srow;
    logic [LSTRIDE_W-1:0]    n_rstride;
    logic [10:0]             n_drow;
    logic [LSTRIDE_W-1:0]    n_dstride;
    logic [10:0]             n_dcol;

    // Stage 3 sums.
    logic signed [SSUM_W-1:0] ssum;
    logic [DST_W:0]           dsum;
    logic signed [SRC_W-1:0]  n_src;
    logic [DST_W-1:0]         n_dst;

    // Take the next command when idle or on the final row of the current one.
    assign o_pop = i_q_valid && (!r_active || (r_cnt == LAST_ROW));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else if (o_pop) begin
            r_active <= 1'b1;
            r_cnt    <= '0;
        end else if (r_active) begin
            if (r_cnt == LAST_ROW) begin
                r_active <= 1'b0;
            end else begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_head;
        end
    end

    // Row classification: plane, field parity, source row and destination row.
    always_comb begin
        is_chroma = (r_cnt >= FIRST_CHR);
        y         = is_chroma ? {1'b0, r_cnt[2:0]} : r_cnt[3:0];
        n_sel     = r_cmd.field & y[0];
        y_off     = r_cmd.field ? {1'b0, y[3:1]} : y;
        sx_pick   = n_sel ? r_cmd.sx_bot : r_cmd.sx_top;
        sy_pick   = n_sel ? r_cmd.sy_bot : r_cmd.sy_top;
        if (is_chroma) begin
            n_sx      = half_tz(sx_pick);
            base_y    = half_tz(sy_pick);
            n_rstride = {1'b0, i_strides.ref_chroma};
            n_dstride = {1'b0, i_strides.dest_chroma};
            n_drow    = {1'b0, r_cmd.row, y[2:0]};
            n_dcol    = {1'b0, r_cmd.col, 3'b000};
        end else begin
            n_sx      = sx_pick;
            base_y    = sy_pick;
            n_rstride = i_strides.ref_luma;
            n_dstride = i_strides.dest_luma;
            n_drow    = {r_cmd.row, y};
            n_dcol    = {r_cmd.col, 4'b0000};
        end
        n_srow = base_y + $signed({{(POS_W-4){1'b0}}, y_off});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_plane   <= is_chroma ? PLANE_CHROMA : PLANE_LUMA;
        r_s1_sel     <= n_sel;
        r_s1_last    <= (r_cnt == LAST_ROW);
        r_s1_srow    <= n_srow;
        r_s1_rstride <= n_rstride;
        r_s1_sx      <= n_sx;
        r_s1_drow    <= n_drow;
        r_s1_dstride <= n_dstride;
        r_s1_dcol    <= n_dcol;
    end

    // Stride multiplications.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_plane <= r_s1_plane;
        r_s2_sel   <= r_s1_sel;
        r_s2_last  <= r_s1_last;
        r_s2_sprod <= SPROD_W'(r_s1_srow) * $signed(SPROD_W'(r_s1_rstride));
        r_s2_sx    <= r_s1_sx;
        r_s2_dprod <= DST_W'(r_s1_drow) * DST_W'(r_s1_dstride);
        r_s2_dcol  <= r_s1_dcol;
    end

    // Column add and saturation.
    always_comb begin
        ssum = SSUM_W'(r_s2_sprod) + SSUM_W'(r_s2_sx);
        dsum = {1'b0, r_s2_dprod} + (DST_W+1)'(r_s2_dcol);
        if (ssum < SRC_LO) begin
            n_src = SRC_LO[SRC_W-1:0];
        end else if (ssum > SRC_HI) begin
            n_src = SRC_HI[SRC_W-1:0];
        end else begin
            n_src = ssum[SRC_W-1:0];
        end
        n_dst = dsum[DST_W] ? {DST_W{1'b1}} : dsum[DST_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_plane <= r_s2_plane;
        r_sel   <= r_s2_sel;
        r_last  <= r_s2_last;
        r_src   <= n_src;
        r_dst   <= n_dst;
    end

    assign o_strobe     = r_strobe;
    assign o_plane      = r_plane;
    assign o_ref_select = r_sel;
    assign o_src_offset = r_src;
    assign o_dst_offset = r_dst;
    assign o_row_length = (r_plane == PLANE_CHROMA) ? LEN_W'(MB_CHROMA) : LEN_W'(MB_LUMA);
    assign o_last       = r_strobe & r_last;

endmodule

// File: hdl/macroblock_motion_copy_address_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// macroblock_motion_copy_address_gen
// Turns one macroblock motion command into 24 row-copy descriptors.
// ----------------------------------------------------------------------------
// The accepted command passes the queue, the row sequencer and the address pipeline.
// Throughput: one descriptor per cycle while a command is in progress, set by
// the row sequencer that issues one row into the address pipeline each cycle.
// A two-entry queue lets up to two further commands be accepted ahead of time.
// Reset is synchronous and active low; strides return to 720 / 360 and all
// queued and in-flight commands are dropped. Results cannot be stalled.
module macroblock_motion_copy_address_gen import mmca_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_operation,
    input  logic [6:0]              i_mb_col,
    input  logic [6:0]              i_mb_row,
    input  logic signed [10:0]      i_mv_x_top,
    input  logic signed [10:0]      i_mv_y_top,
    input  logic signed [10:0]      i_mv_x_bottom,
    input  logic signed [10:0]      i_mv_y_bottom,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [LSTRIDE_W-1:0]    i_cfg_data,
    output logic                    o_strobe,
    output logic                    o_plane,
    output logic                    o_ref_select,
    output logic signed [SRC_W-1:0] o_src_offset,
    output logic [DST_W-1:0]        o_dst_offset,
    output logic [LEN_W-1:0]        o_row_length,
    output logic                    o_last
);

    t_strides r_strides;
    t_cmd     front_cmd;
    t_cmd     q_head;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    logic     accept;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strides.ref_luma    <= LSTRIDE_W'(720);
            r_strides.dest_luma   <= LSTRIDE_W'(720);
            r_strides.ref_chroma  <= CSTRIDE_W'(360);
            r_strides.dest_chroma <= CSTRIDE_W'(360);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_REF_LUMA_STRIDE:    r_strides.ref_luma    <= i_cfg_data;
                REG_DEST_LUMA_STRIDE:   r_strides.dest_luma   <= i_cfg_data;
                REG_REF_CHROMA_STRIDE:  r_strides.ref_chroma  <= i_cfg_data[CSTRIDE_W-1:0];
                REG_DEST_CHROMA_STRIDE: r_strides.dest_chroma <= i_cfg_data[CSTRIDE_W-1:0];
                default:                r_strides             <= r_strides;
            endcase
        end
    end

    // Command acceptance.
    assign busy   = q_full;
    assign accept = start && !busy;

    mmca_front u_front (
        .i_operation   (i_operation),
        .i_mb_col      (i_mb_col),
        .i_mb_row      (i_mb_row),
        .i_mv_x_top    (i_mv_x_top),
        .i_mv_y_top    (i_mv_y_top),
        .i_mv_x_bottom (i_mv_x_bottom),
        .i_mv_y_bottom (i_mv_y_bottom),
        .o_cmd         (front_cmd)
    );

    mmca_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    mmca_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_head     (q_head),
        .i_strides    (r_strides),
        .o_pop        (q_pop),
        .o_strobe     (o_strobe),
        .o_plane      (o_plane),
        .o_ref_select (o_ref_select),
        .o_src_offset (o_src_offset),
        .o_dst_offset (o_dst_offset),
        .o_row_length (o_row_length),
        .o_last       (o_last)
    );

endmodule

// File: hdl/mmca_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmca_checker
// Port-level checks of the descriptor stream of the address generator.
// ----------------------------------------------------------------------------
module mmca_checker import mmca_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             busy,
    input logic             o_strobe,
    input logic             o_plane,
    input logic [LEN_W-1:0] o_row_length,
    input logic             o_last
);

    // Reset empties the pipeline and the queue.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe && !busy)
        else $error("strobe or busy high after reset");

    // Row length follows the plane.
    a_len_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_plane ? (o_row_length == LEN_W'(MB_CHROMA))
                              : (o_row_length == LEN_W'(MB_LUMA))))
        else $error("row length does not match plane");

    // The final descriptor of a macroblock is a chroma row.
    a_last_chroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_strobe && o_plane)
        else $error("last flag outside a chroma row");

    // Luma rows are always followed by another row of the same macroblock.
    a_luma_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_plane |=> o_strobe)
        else $error("gap inside the luma rows");

    // Chroma rows run without a gap until the last one.
    a_chroma_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_plane && !o_last |=> o_strobe && o_plane)
        else $error("gap inside the chroma rows");

endmodule

bind macroblock_motion_copy_address_gen mmca_checker u_mmca_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_plane      (o_plane),
    .o_row_length (o_row_length),
    .o_last       (o_last)
);

// File: sim/tb_macroblock_motion_copy_address_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_macroblock_motion_copy_address_gen
// Self-checking bench for the macroblock motion copy address generator. A
// driver plays queued macroblock commands in random bursts, and a monitor
// compares every strobed row descriptor with the descriptors predicted from
// the command and the current stride registers. The strides are reprogrammed
// between phases while the block is idle, covering the reset values, the
// largest and smallest values, zero and random settings.
// ----------------------------------------------------------------------------
module tb_macroblock_motion_copy_address_gen;
    import mmca_pkg::*;

    localparam int     CLK_HALF    = 5;
    localparam int     RESET_TICKS = 7;
    localparam int     CYCLE_LIMIT = 300000;
    localparam int     DRAIN_TICKS = 10;
    localparam longint SRC_LO      = -(longint'(1) <<< (SRC_W - 1));
    localparam longint SRC_HI      = (longint'(1) <<< (SRC_W - 1)) - 1;
    localparam longint DST_HI      = (longint'(1) << DST_W) - 1;

    // One macroblock command as the bench holds it.
    typedef struct {
        logic               op;
        logic [6:0]         col;
        logic [6:0]         row;
        logic signed [10:0] mvx_top;
        logic signed [10:0] mvy_top;
        logic signed [10:0] mvx_bot;
        logic signed [10:0] mvy_bot;
    } t_mb_cmd;

    // One row-copy descriptor.
    typedef struct {
        logic                    plane;
        logic                    ref_sel;
        logic signed [SRC_W-1:0] src;
        logic [DST_W-1:0]        dst;
        logic [LEN_W-1:0]        len;
        logic                    last;
    } t_row_desc;

    // One stride register write.
    typedef struct {
        t_reg_idx             idx;
        logic [LSTRIDE_W-1:0] data;
    } t_stride_write;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    start         = 1'b0;
    logic                    busy;
    logic                    i_operation   = OP_FRAME;
    logic [6:0]              i_mb_col      = '0;
    logic [6:0]              i_mb_row      = '0;
    logic signed [10:0]      i_mv_x_top    = '0;
    logic signed [10:0]      i_mv_y_top    = '0;
    logic signed [10:0]      i_mv_x_bottom = '0;
    logic signed [10:0]      i_mv_y_bottom = '0;
    logic                    i_cfg_valid   = 1'b0;
    logic                    o_cfg_ready;
    logic [1:0]              i_cfg_index   = REG_REF_LUMA_STRIDE;
    logic [LSTRIDE_W-1:0]    i_cfg_data    = '0;
    logic                    o_strobe;
    logic                    o_plane;
    logic                    o_ref_select;
    logic signed [SRC_W-1:0] o_src_offset;
    logic [DST_W-1:0]        o_dst_offset;
    logic [LEN_W-1:0]        o_row_length;
    logic                    o_last;

    t_mb_cmd       pending_cmds [$];
    t_row_desc     expected_rows [$];
    t_stride_write stride_writes [$];
    t_mb_cmd       held_cmd;
    t_strides      pitches = '{ref_luma: LSTRIDE_W'(720), dest_luma: LSTRIDE_W'(720),
                               ref_chroma: CSTRIDE_W'(360),
                               dest_chroma: CSTRIDE_W'(360)};
    int            error_count = 0;
    int            burst_left  = 0;
    int            gap_left    = 0;
    int            cycle_count = 0;

    macroblock_motion_copy_address_gen dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_mb_col      (i_mb_col),
        .i_mb_row      (i_mb_row),
        .i_mv_x_top    (i_mv_x_top),
        .i_mv_y_top    (i_mv_y_top),
        .i_mv_x_bottom (i_mv_x_bottom),
        .i_mv_y_bottom (i_mv_y_bottom),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_strobe      (o_strobe),
        .o_plane       (o_plane),
        .o_ref_select  (o_ref_select),
        .o_src_offset  (o_src_offset),
        .o_dst_offset  (o_dst_offset),
        .o_row_length  (o_row_length),
        .o_last        (o_last)
    );

    // Free-running clock.
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic longint clamp_offset(longint v, longint lo, longint hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // Works out the 24 row descriptors of one command and queues them.
    function automatic void predict_rows(input t_mb_cmd c);
        longint    sx [2];
        longint    sy [2];
        longint    col, row, srow, src, dst, rls, dls, rcs, dcs;
        int        p, cy;
        bit        field;
        t_row_desc d;
        field = (c.op == OP_FIELD);
        col   = longint'(c.col);
        row   = longint'(c.row);
        rls   = longint'(pitches.ref_luma);
        dls   = longint'(pitches.dest_luma);
        rcs   = longint'(pitches.ref_chroma);
        dcs   = longint'(pitches.dest_chroma);
        sx[0] = col * MB_LUMA + longint'(c.mvx_top);
        sy[0] = row * MB_LUMA + longint'(c.mvy_top);
        sx[1] = col * MB_LUMA + longint'(c.mvx_bot);
        sy[1] = row * MB_LUMA + longint'(c.mvy_bot);
        for (int y = 0; y < NUM_ROWS; y++) begin
            p = field ? (y % 2) : 0;
            if (y < MB_LUMA) begin
                srow    = field ? sy[p] + y / 2 : sy[0] + y;
                src     = srow * rls + sx[p];
                dst     = (row * MB_LUMA + y) * dls + col * MB_LUMA;
                d.plane = PLANE_LUMA;
                d.len   = LEN_W'(MB_LUMA);
            end else begin
                // Chroma halves the luma position, rounding toward zero.
                cy      = y - MB_LUMA;
                srow    = field ? sy[p] / 2 + cy / 2 : sy[p] / 2 + cy;
                src     = srow * rcs + sx[p] / 2;
                dst     = (row * MB_CHROMA + cy) * dcs + col * MB_CHROMA;
                d.plane = PLANE_CHROMA;
                d.len   = LEN_W'(MB_CHROMA);
            end
            d.ref_sel = p[0];
            d.src     = SRC_W'(clamp_offset(src, SRC_LO, SRC_HI));
            d.dst     = DST_W'(clamp_offset(dst, 0, DST_HI));
            d.last    = (y == NUM_ROWS - 1);
            expected_rows.push_back(d);
        end
    endfunction

    function automatic void check_field(string name, logic signed [31:0] exp_v,
                                        logic signed [31:0] act_v);
        if (act_v !== exp_v) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
        end
    endfunction

    function automatic t_mb_cmd make_cmd(logic op, int col, int row, int xt, int yt,
                                         int xb, int yb);
        t_mb_cmd c;
        c.op      = op;
        c.col     = 7'(col);
        c.row     = 7'(row);
        c.mvx_top = 11'(xt);
        c.mvy_top = 11'(yt);
        c.mvx_bot = 11'(xb);
        c.mvy_bot = 11'(yb);
        return c;
    endfunction

    // Vector component biased toward the extremes and small values.
    function automatic logic signed [10:0] pick_vector();
        case ($urandom_range(0, 7))
            0: return -11'sd1024;
            1: return 11'sd1023;
            2: return 11'($urandom_range(0, 16) - 8);
            default: return 11'($urandom_range(0, 2047));
        endcase
    endfunction

    function automatic logic [6:0] pick_position();
        case ($urandom_range(0, 7))
            0: return 7'd0;
            1: return 7'd127;
            default: return 7'($urandom_range(0, 127));
        endcase
    endfunction

    // Command driver: one command per start transaction, in random bursts.
    always @(posedge i_clk) begin
        t_mb_cmd c;
        if (start && !busy) begin
            predict_rows(held_cmd);
        end
        if (!start || !busy) begin
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                c             = pending_cmds.pop_front();
                held_cmd      = c;
                i_operation   <= c.op;
                i_mb_col      <= c.col;
                i_mb_row      <= c.row;
                i_mv_x_top    <= c.mvx_top;
                i_mv_y_top    <= c.mvy_top;
                i_mv_x_bottom <= c.mvx_bot;
                i_mv_y_bottom <= c.mvy_bot;
                start         <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Stride register driver and shadow copy of the registers.
    always @(posedge i_clk) begin
        t_stride_write w;
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (t_reg_idx'(i_cfg_index))
                REG_REF_LUMA_STRIDE:    pitches.ref_luma    = i_cfg_data;
                REG_DEST_LUMA_STRIDE:   pitches.dest_luma   = i_cfg_data;
                REG_REF_CHROMA_STRIDE:  pitches.ref_chroma  = i_cfg_data[CSTRIDE_W-1:0];
                REG_DEST_CHROMA_STRIDE: pitches.dest_chroma = i_cfg_data[CSTRIDE_W-1:0];
                default: ;
            endcase
        end
        if (!i_cfg_valid || o_cfg_ready) begin
            if (stride_writes.size() > 0) begin
                w           = stride_writes.pop_front();
                i_cfg_valid <= 1'b1;
                i_cfg_index <= w.idx;
                i_cfg_data  <= w.data;
            end else begin
                i_cfg_valid <= 1'b0;
            end
        end
    end

    // Descriptor monitor: each strobe is one transaction that cannot be held off.
    always @(posedge i_clk) begin
        t_row_desc e;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (expected_rows.size() == 0) begin
                error_count++;
                $display("%0t: descriptor with none expected, src %0d dst %0d",
                         $time, o_src_offset, o_dst_offset);
            end else begin
                e = expected_rows.pop_front();
                check_field("plane", 32'(e.plane), 32'(o_plane));
                check_field("ref_select", 32'(e.ref_sel), 32'(o_ref_select));
                check_field("src_offset", 32'(e.src), 32'(o_src_offset));
                check_field("dst_offset", 32'(e.dst), 32'(o_dst_offset));
                check_field("row_length", 32'(e.len), 32'(o_row_length));
                check_field("last", 32'(e.last), 32'(o_last));
            end
        end
    end

    // Guard against a hung block.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (pending_cmds.size() != 0 || start || expected_rows.size() != 0);
    endtask

    task automatic write_strides(int ref_l, int dst_l, int ref_c, int dst_c);
        stride_writes.push_back('{REG_REF_LUMA_STRIDE, LSTRIDE_W'(ref_l)});
        stride_writes.push_back('{REG_DEST_LUMA_STRIDE, LSTRIDE_W'(dst_l)});
        stride_writes.push_back('{REG_REF_CHROMA_STRIDE, LSTRIDE_W'(ref_c)});
        stride_writes.push_back('{REG_DEST_CHROMA_STRIDE, LSTRIDE_W'(dst_c)});
        do begin
            @(negedge i_clk);
        end while (stride_writes.size() != 0 || i_cfg_valid);
    endtask

    task automatic queue_random(int count);
        repeat (count) begin
            pending_cmds.push_back(make_cmd(1'($urandom_range(0, 1)),
                                            int'(pick_position()),
                                            int'(pick_position()),
                                            int'(pick_vector()), int'(pick_vector()),
                                            int'(pick_vector()), int'(pick_vector())));
        end
        wait_idle();
    endtask

    // Test sequence: phases of stride settings, each run to completion.
    initial begin
        repeat (RESET_TICKS) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset strides.
        queue_random(50);

        // Largest strides; the reference chroma write also carries a set top bit.
        write_strides(8191, 8191, 8191, 4095);
        pending_cmds.push_back(make_cmd(OP_FRAME, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_FRAME, 127, 127, 1023, 1023, -1024, -1024));
        pending_cmds.push_back(make_cmd(OP_FRAME, 0, 0, -1024, -1024, 1023, 1023));
        pending_cmds.push_back(make_cmd(OP_FIELD, 127, 127, 1023, 1023, -1024, -1024));
        pending_cmds.push_back(make_cmd(OP_FIELD, 0, 0, -1024, -1024, 1023, 1023));
        // Odd negative sums, where chroma halving must round toward zero.
        pending_cmds.push_back(make_cmd(OP_FIELD, 0, 0, -1, -1, -3, -3));
        pending_cmds.push_back(make_cmd(OP_FRAME, 1, 1, -17, -17, 5, 5));
        pending_cmds.push_back(make_cmd(OP_FIELD, 64, 64, 5, -7, -9, 11));
        pending_cmds.push_back(make_cmd(OP_FRAME, 127, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_FRAME, 0, 127, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(OP_FIELD, 100, 3, 1023, -1024, -1024, 1023));
        pending_cmds.push_back(make_cmd(OP_FIELD, 0, 0, 0, 0, 0, 0));
        queue_random(50);

        // Zero strides repeat one row; then the smallest legal strides.
        write_strides(0, 0, 0, 0);
        queue_random(30);
        write_strides(1, 1, 1, 1);
        queue_random(30);

        repeat (2) begin
            write_strides($urandom_range(0, 8191), $urandom_range(0, 8191),
                          $urandom_range(0, 8191), $urandom_range(0, 8191));
            queue_random(45);
        end

        // Let any stray descriptor show itself before closing.
        repeat (DRAIN_TICKS) @(posedge i_clk);
        if (error_count == 0 && expected_rows.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
